[hw/rtl/bilinear_grid_resampler_macros.svh]
// Assertion macros for the bilinear grid resampler RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef BILINEAR_GRID_RESAMPLER_MACROS_SVH
`define BILINEAR_GRID_RESAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BGR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BGR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/bgr_pkg.sv]
// Shared types and constants for the bilinear grid resampler.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps
`default_nettype none

package bgr_pkg;

  localparam int PIX_W      = 12;
  localparam int COORD_W    = 8;
  localparam int SMP_W      = 16;
  localparam int STEP_W     = 24;
  localparam int FRAC_W     = 17;              // Q0.17 weight
  localparam int U_W        = 38;              // (2p+1)*step + 2^16
  localparam int HI_W       = U_W - FRAC_W;    // integer part of u
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic REG_STEP_X = 1'b0;
  localparam logic REG_STEP_Y = 1'b1;

  localparam logic [STEP_W-1:0] STEP_RESET = 24'h010000;  // 1.0 in Q8.16

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_y;
    logic [PIX_W-1:0]   pixel_x;
    logic [SMP_W-1:0]   sample_value;
    logic [COORD_W-1:0] grid_row;
    logic [COORD_W-1:0] grid_col;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] echo_y;
    logic [PIX_W-1:0] echo_x;
    logic [SMP_W-1:0] blended_value;
  } out_item_t;

endpackage

`default_nettype wire

[hw/rtl/bgr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hw/rtl/bilinear_grid_resampler.sv]
// Bilinear resampler over a stored grid of Q0.16 nearness samples.
// Depends on bgr_pkg, bgr_ram and bilinear_grid_resampler_macros.svh.
//
//   channel | direction | ports                      | carries
//   --------+-----------+----------------------------+-------------------------------
//   in      | in        | in_tvalid/tready/tdata/tuser | grid load or pixel query
//   out     | out       | out_tvalid/tready/tdata    | blended sample + pixel echo
//   cfg     | in        | cfg_valid/ready/index/data | step_x (0), step_y (1)
//
// One item at a time: a load writes its sample in the map step, and a query passes
// through map multiply, clamp, bank read and two blend multiplies in sequence before
// its result is registered at the output.
// The grid sits in four parity banks so all four neighbors come from one read.
// Reset is synchronous; the grid is not cleared, only control state is.
// A finished result waits in the output register; the next item is taken
// meanwhile, and a query stalls in its last step only if that register is full.
`timescale 1ns / 1ps
`default_nettype none
`include "bilinear_grid_resampler_macros.svh"

module bilinear_grid_resampler #(
  parameter int GRID_W = 256,
  parameter int GRID_H = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] grid_col, [15:8] grid_row, [31:16] sample_value,
  // [43:32] pixel_x, [55:44] pixel_y
  input  logic [bgr_pkg::IN_DATA_W-1:0]     in_tdata,
  // [0] kind
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [15:0] blended_value, [27:16] echo_x, [39:28] echo_y
  output logic [bgr_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [0:0]                        cfg_index,
  input  logic [bgr_pkg::STEP_W-1:0]        cfg_data
);

  import bgr_pkg::*;

  localparam int XW     = $clog2(GRID_W);
  localparam int YW     = $clog2(GRID_H);
  localparam int HW     = (GRID_W + 1) / 2;
  localparam int HH     = (GRID_H + 1) / 2;
  localparam int BDEPTH = HW * HH;
  localparam int BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

  localparam logic [10:0]     GRID_W_L = 11'(GRID_W);
  localparam logic [10:0]     GRID_H_L = 11'(GRID_H);
  localparam logic [HI_W-1:0] LAST_X   = HI_W'(GRID_W - 1);
  localparam logic [HI_W-1:0] LAST_Y   = HI_W'(GRID_H - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAP   = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_MIX1  = 3'd4;
  localparam logic [2:0] S_MIX2  = 3'd5;

  function automatic logic [BAW-1:0] bank_addr(logic [10:0] r, logic [10:0] c);
    logic [21:0] a;
    a = 22'(r >> 1) * 22'(HW) + 22'(c >> 1);
    return a[BAW-1:0];
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_x_r, step_y_r;
  in_item_t          item_r;
  logic              kind_r;
  logic [U_W-1:0]    ux_r, uy_r;
  logic [XW-1:0]     x0_r, x1_r;
  logic [YW-1:0]     y0_r, y1_r;
  logic [FRAC_W-1:0] tx_r, ty_r;
  logic signed [34:0] top_r, bot_r;
  out_item_t         out_r;
  logic              out_tvalid_r;

  logic              in_acc;
  logic              out_load;

  // Coordinate mapping
  logic [36:0]       px_prod, py_prod;
  logic [HI_W-1:0]   hi_x, hi_y, hm_x, hm_y, x0_w, x1_w, y0_w, y1_w;

  // Grid banks, index {row parity, column parity}
  logic              wr_ok;
  logic [1:0]        wr_bank;
  logic [BAW-1:0]    wr_addr;
  logic [SMP_W-1:0]  rd_data [4];
  logic [BAW-1:0]    rd_addr [4];

  // Blend
  logic [SMP_W-1:0]   smp_a, smp_b, smp_c, smp_d;
  logic signed [16:0] diff_ab, diff_cd;
  logic signed [34:0] prod_ab, prod_cd;
  logic signed [34:0] diff_tb;
  logic signed [52:0] prod_tb, acc;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_load   = (state_r == S_MIX2) && (!out_tvalid_r || out_tready);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_MAP;
      S_MAP:   state_nxt = (kind_r == KIND_QUERY) ? S_CLAMP : S_IDLE;
      S_CLAMP: state_nxt = S_READ;
      S_READ:  state_nxt = S_MIX1;
      S_MIX1:  state_nxt = S_MIX2;
      S_MIX2:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_tvalid_r <= 1'b0;
      step_x_r     <= STEP_RESET;
      step_y_r     <= STEP_RESET;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_STEP_X: step_x_r <= cfg_data;
          REG_STEP_Y: step_y_r <= cfg_data;
          default:    ;
        endcase
      end
    end
  end

  // u = (2p+1)*step + 2^16 is the grid coordinate plus one, in Q.17
  assign px_prod = {item_r.pixel_x, 1'b1} * step_x_r;
  assign py_prod = {item_r.pixel_y, 1'b1} * step_y_r;

  assign hi_x = ux_r[U_W-1:FRAC_W];
  assign hi_y = uy_r[U_W-1:FRAC_W];
  assign hm_x = hi_x - HI_W'(1);
  assign hm_y = hi_y - HI_W'(1);
  assign x1_w = (hi_x > LAST_X) ? LAST_X : hi_x;
  assign y1_w = (hi_y > LAST_Y) ? LAST_Y : hi_y;
  assign x0_w = (hi_x == '0) ? '0 : ((hm_x > LAST_X) ? LAST_X : hm_x);
  assign y0_w = (hi_y == '0) ? '0 : ((hm_y > LAST_Y) ? LAST_Y : hm_y);

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_item_t'(in_tdata);
      kind_r <= in_tuser[0];
    end
    if (state_r == S_MAP) begin
      ux_r <= U_W'(px_prod) + U_W'(65536);
      uy_r <= U_W'(py_prod) + U_W'(65536);
    end
    if (state_r == S_CLAMP) begin
      x0_r <= x0_w[XW-1:0];
      x1_r <= x1_w[XW-1:0];
      y0_r <= y0_w[YW-1:0];
      y1_r <= y1_w[YW-1:0];
      tx_r <= ux_r[FRAC_W-1:0];
      ty_r <= uy_r[FRAC_W-1:0];
    end
    if (state_r == S_MIX1) begin
      top_r <= $signed({2'b00, smp_a, 17'b0}) + prod_ab;
      bot_r <= $signed({2'b00, smp_c, 17'b0}) + prod_cd;
    end
    if (out_load) begin
      out_r.blended_value <= acc[49:34];
      out_r.echo_x        <= item_r.pixel_x;
      out_r.echo_y        <= item_r.pixel_y;
    end
  end

  // Loads outside the grid are dropped
  assign wr_ok   = (state_r == S_MAP) && (kind_r == KIND_LOAD) &&
                   ({3'b000, item_r.grid_col} < GRID_W_L) &&
                   ({3'b000, item_r.grid_row} < GRID_H_L);
  assign wr_bank = {item_r.grid_row[0], item_r.grid_col[0]};
  assign wr_addr = bank_addr({3'b000, item_r.grid_row}, {3'b000, item_r.grid_col});

  for (genvar k = 0; k < 4; k++) begin : g_bank
    localparam logic COL_PAR = 1'(k % 2);
    localparam logic ROW_PAR = 1'(k / 2);

    logic [XW-1:0] col_sel;
    logic [YW-1:0] row_sel;

    // Each bank serves whichever neighbor has its parity
    assign col_sel    = (x0_r[0] == COL_PAR) ? x0_r : x1_r;
    assign row_sel    = (y0_r[0] == ROW_PAR) ? y0_r : y1_r;
    assign rd_addr[k] = bank_addr(11'(row_sel), 11'(col_sel));

    bgr_ram #(
      .WIDTH (SMP_W),
      .DEPTH (BDEPTH),
      .AW    (BAW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (wr_ok && (wr_bank == 2'(k))),
      .wr_addr (wr_addr),
      .wr_data (item_r.sample_value),
      .rd_en   (state_r == S_READ),
      .rd_addr (rd_addr[k]),
      .rd_data (rd_data[k])
    );
  end

  assign smp_a = rd_data[{y0_r[0], x0_r[0]}];
  assign smp_b = rd_data[{y0_r[0], x1_r[0]}];
  assign smp_c = rd_data[{y1_r[0], x0_r[0]}];
  assign smp_d = rd_data[{y1_r[0], x1_r[0]}];

  assign diff_ab = $signed({1'b0, smp_b}) - $signed({1'b0, smp_a});
  assign diff_cd = $signed({1'b0, smp_d}) - $signed({1'b0, smp_c});
  assign prod_ab = $signed({1'b0, tx_r}) * diff_ab;
  assign prod_cd = $signed({1'b0, tx_r}) * diff_cd;

  // Convex blend: acc stays in [0, 2^50), Q.34
  assign diff_tb = bot_r - top_r;
  assign prod_tb = $signed({1'b0, ty_r}) * diff_tb;
  assign acc     = $signed({top_r[34], top_r, 17'b0}) + prod_tb;

  `BGR_ASSERT_NXT(a_accept_to_map, in_acc, state_r == S_MAP, "accepted item did not start")
  `BGR_ASSERT_IMP(a_result_from_blend, $rose(out_tvalid_r), $past(state_r) == S_MIX2, "result not from blend step")
  `BGR_ASSERT_IMP(a_x_order, state_r == S_READ, (x0_r <= x1_r) && (x1_r - x0_r <= XW'(1)), "column neighbors out of order")
  `BGR_ASSERT_IMP(a_y_order, state_r == S_READ, (y0_r <= y1_r) && (y1_r - y0_r <= YW'(1)), "row neighbors out of order")
  `BGR_ASSERT_IMP(a_no_write_in_query, kind_r == KIND_QUERY, !wr_ok, "grid written by a query")

endmodule

`default_nettype wire
